// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define OLT_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define OLT_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/olt_pkg.sv =====
`default_nettype none
package olt_pkg;

    localparam int CAPACITY   = 64;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 4;
    localparam int POS_W      = 7;
    localparam int STAT_W     = 3;
    localparam int OUT_CNT_W  = 7;
    localparam int OUT_IDX_W  = 7;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 56;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_ERASE      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FIND       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ONE = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 4'd8;
    localparam logic [CMD_W-1:0] CMD_FRONT      = 4'd9;
    localparam logic [CMD_W-1:0] CMD_BACK       = 4'd10;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OUT_CNT_W-1:0] count;
        logic [OUT_IDX_W-1:0] found_index;
        logic [DATA_W-1:0]    read_value;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage
`default_nettype wire

// ===== design/olt_store.sv =====
`default_nettype none
module olt_store (
    input  wire logic                      aclk,
    input  wire olt_pkg::mem_req_t         mem_req,
    output logic [olt_pkg::DATA_W-1:0]     rd_data
);
    import olt_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[mem_req.rd_addr];
    end

endmodule
`default_nettype wire

// ===== design/olt_ctrl.sv =====
`default_nettype none
module olt_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire olt_pkg::req_t          in_req,
    output olt_pkg::mem_req_t           mem_req,
    input  wire logic [olt_pkg::DATA_W-1:0] mem_rdata,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output olt_pkg::result_t            res
);
    import olt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 dv_reg, dv_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [CNT_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [STAT_W-1:0]    stat_reg, stat_next;
    logic [OUT_IDX_W-1:0] fidx_reg, fidx_next;
    logic [DATA_W-1:0]    rval_reg, rval_next;

    logic [POS_W+CNT_W-1:0]     cnt_w, pos_w, ins_pos_w;
    logic [OUT_IDX_W+ADDR_W-1:0] idx_ext;
    logic [OUT_CNT_W+CNT_W-1:0]  cnt_ext;
    logic is_empty, is_full, issue, hit, skip;

    assign cnt_w    = {{POS_W{1'b0}}, cnt_reg};
    assign pos_w    = {{CNT_W{1'b0}}, in_req.position};
    assign idx_ext  = {{OUT_IDX_W{1'b0}}, idx_reg};
    assign cnt_ext  = {{OUT_CNT_W{1'b0}}, cnt_reg};
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg >= CNT_W'(CAPACITY));

    always_comb begin
        unique case (in_req.cmd)
            CMD_PUSH_BACK:  ins_pos_w = cnt_w;
            CMD_PUSH_FRONT: ins_pos_w = '0;
            default:        ins_pos_w = pos_w;
        endcase
    end

    // erase and pop_front drop a position; the remove commands drop matches
    assign hit = (cmd_reg == CMD_ERASE || cmd_reg == CMD_POP_FRONT) ?
                 (idx_reg == pos_reg) : (mem_rdata == val_reg);
    assign skip = hit && (cmd_reg == CMD_REMOVE_ALL || !found_reg);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        dv_next     = dv_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        left_next   = left_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        stat_next   = stat_reg;
        fidx_next   = fidx_reg;
        rval_next   = rval_reg;
        issue       = 1'b0;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = wr_ptr_reg[ADDR_W-1:0];
        mem_req.wr_data = mem_rdata;
        mem_req.rd_addr = rd_ptr_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next    = in_req.cmd;
                    val_next    = in_req.value;
                    stat_next   = ST_OK;
                    fidx_next   = '1;
                    rval_next   = '0;
                    found_next  = 1'b0;
                    dv_next     = 1'b0;
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    state_next  = S_FIN;
                    unique case (in_req.cmd)
                        CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
                            if (ins_pos_w > cnt_w) begin
                                stat_next = ST_BADPOS;
                            end else if (is_full) begin
                                stat_next = ST_FULL;
                            end else begin
                                pos_next    = ins_pos_w[ADDR_W-1:0];
                                left_next   = cnt_reg - ins_pos_w[CNT_W-1:0];
                                rd_ptr_next = cnt_reg - CNT_W'(1);
                                state_next  = (ins_pos_w == cnt_w) ? S_PUT : S_UP;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (is_empty) stat_next = ST_EMPTY;
                            else cnt_next = cnt_reg - CNT_W'(1);
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty) begin
                                stat_next = ST_EMPTY;
                            end else begin
                                pos_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_ERASE: begin
                            if (pos_w >= cnt_w) begin
                                stat_next = ST_BADPOS;
                            end else begin
                                pos_next   = pos_w[ADDR_W-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        CMD_FIND: begin
                            if (is_empty) stat_next = ST_NOTFOUND;
                            else state_next = S_SCAN;
                        end
                        CMD_REMOVE_ONE, CMD_REMOVE_ALL: begin
                            if (is_empty) stat_next = ST_EMPTY;
                            else state_next = S_SCAN;
                        end
                        CMD_FRONT: begin
                            if (is_empty) stat_next = ST_EMPTY;
                            else state_next = S_READ;
                        end
                        CMD_BACK: begin
                            if (is_empty) begin
                                stat_next = ST_EMPTY;
                            end else begin
                                rd_ptr_next = cnt_reg - CNT_W'(1);
                                state_next  = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UP: begin
                // read j, write it back at j+1 in the next cycle, top down
                if (dv_reg) begin
                    mem_req.wr_en = 1'b1;
                end
                if (left_reg != '0) begin
                    rd_ptr_next = rd_ptr_reg - CNT_W'(1);
                    left_next   = left_reg - CNT_W'(1);
                    wr_ptr_next = rd_ptr_reg + CNT_W'(1);
                    dv_next     = 1'b1;
                end else begin
                    dv_next = 1'b0;
                    if (!dv_reg) state_next = S_PUT;
                end
            end
            S_PUT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                mem_req.wr_data = val_reg;
                cnt_next        = cnt_reg + CNT_W'(1);
                state_next      = S_FIN;
            end
            S_SCAN: begin
                // compaction pass (find only scans): keepers are written back at the write pointer
                issue = (rd_ptr_reg < cnt_reg);
                if (issue) begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    idx_next    = rd_ptr_reg[ADDR_W-1:0];
                    dv_next     = 1'b1;
                end else begin
                    dv_next = 1'b0;
                end
                if (dv_reg) begin
                    if (hit && !found_reg) begin
                        found_next = 1'b1;
                        if (cmd_reg == CMD_FIND) fidx_next = idx_ext[OUT_IDX_W-1:0];
                    end
                    if (cmd_reg != CMD_FIND && !skip) begin
                        mem_req.wr_en = 1'b1;
                        wr_ptr_next   = wr_ptr_reg + CNT_W'(1);
                    end
                end
                if (!issue && !dv_reg) begin
                    stat_next = found_reg ? ST_OK : ST_NOTFOUND;
                    if (cmd_reg != CMD_FIND) cnt_next = wr_ptr_reg;
                    state_next = S_FIN;
                end
            end
            S_READ: begin
                if (!dv_reg) begin
                    dv_next = 1'b1;
                end else begin
                    rval_next  = mem_rdata;
                    dv_next    = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (res_ready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dv_reg    <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        left_reg   <= left_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        stat_reg   <= stat_next;
        fidx_reg   <= fidx_next;
        rval_reg   <= rval_next;
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_FIN);
    assign res.status      = stat_reg;
    assign res.count       = cnt_ext[OUT_CNT_W-1:0];
    assign res.found_index = fidx_reg;
    assign res.read_value  = rval_reg;

endmodule
`default_nettype wire

// ===== design/ordered_list_table.sv =====
// Channel  Dir  tdata                                   tuser
// s_       in   [6:0] position, [38:7] value, pad        [3:0] cmd
// m_       out  [2:0] status, [9:3] count,                none
//               [16:10] found_index, [48:17] read_value
//
// One request at a time. pop_back, unused codes and error cases go straight to
// the result, push_back writes one element, front/back read one, insert first
// shifts the elements from the position up, and erase, pop_front, find and removes
// scan the element memory through its single read port. Reset (aresetn, synchronous,
// low) empties the list. A held result does not block acceptance of the next request.
`default_nettype none
`include "assert_macros.svh"
module ordered_list_table (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [6:0] position, [38:7] value, [39] zero
    input  wire logic [olt_pkg::IN_DATA_W-1:0]      s_tdata,
    // [3:0] cmd
    input  wire logic [olt_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [2:0] status, [9:3] count, [16:10] found_index, [48:17] read_value, rest zero
    output logic [olt_pkg::OUT_DATA_W-1:0]          m_tdata
);
    import olt_pkg::*;

    req_t              in_req;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              res_valid, res_ready;
    result_t           res;
    logic              m_valid_reg, m_valid_next;
    result_t           m_res_reg;

    assign in_req.cmd      = s_tuser[CMD_W-1:0];
    assign in_req.position = s_tdata[POS_W-1:0];
    assign in_req.value    = s_tdata[POS_W+DATA_W-1:POS_W];

    olt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    olt_store u_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) m_valid_next = 1'b1;
        else if (m_tready)          m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) m_res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - STAT_W - OUT_CNT_W - OUT_IDX_W - DATA_W){1'b0}},
                       m_res_reg.read_value, m_res_reg.found_index,
                       m_res_reg.count, m_res_reg.status};

    `OLT_ASSERT_NXT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "request accepted while a request is in work")
    `OLT_ASSERT_IMP(a_full_count, aclk, aresetn,
        m_tvalid && m_res_reg.status == ST_FULL,
        m_res_reg.count == OUT_CNT_W'(CAPACITY), "full status with count below capacity")
    `OLT_ASSERT_IMP(a_empty_count, aclk, aresetn,
        m_tvalid && m_res_reg.status == ST_EMPTY,
        m_res_reg.count == '0, "empty status with nonzero count")
    `OLT_ASSERT_IMP(a_index_ok, aclk, aresetn,
        m_tvalid && m_res_reg.found_index != '1,
        m_res_reg.status == ST_OK, "found index without ok status")

endmodule
`default_nettype wire
